@@ src/cfre_pkg.sv @@
// Types and constants shared by the coarse/fine residual engine and its checker.
// No dependencies.
`default_nettype none

package cfre_pkg;

   // Field widths, fixed by the point format (signed Q15.16 values)
   localparam int COORD_BITS = 16;
   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 16;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [VALUE_BITS-1:0] value_type;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_LOAD  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_SPARE = 2'd3
   } kind_type;

   // Value of an absent neighbor: -1.0 in the value format
   localparam value_type MINUS_ONE = value_type'(-(longint'(1) <<< FRAC_BITS));
   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef struct packed {
      kind_type  kind;
      coord_type coord_x;
      coord_type coord_y;
      value_type sample_value;
   } req_type;

   typedef struct packed {
      value_type delta;
      logic      neighbor_missing;
      logic      saturated;
   } rsp_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } key_type;

   typedef struct packed {
      key_type   key;
      value_type value;
   } entry_type;

   // floor((a + b) / 2) without overflow
   function automatic value_type half_blend(input value_type a, input value_type b);
      logic signed [VALUE_BITS:0] sum;
      sum = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
      return sum[VALUE_BITS:1];
   endfunction

endpackage

`default_nettype wire

@@ src/coarse_fine_residual_engine.sv @@
// Coarse/fine residual engine top level: coarse point table in one synchronous
// memory, table scan sequencer, bilinear blend and saturating subtract.
// Depends on cfre_pkg.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries clear, load and query
//   beats; a beat is taken when req_valid is high and req_stall low.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) returns one beat per query that
//   finds its parent; queries without a parent return nothing.
//   csr channel writes interpolate_mode; csr_ready is always high. Write it
//   only while the block is idle.
// Operation:
//   clear and load leave the block idle. A query scans every loaded entry
//   through the table memory's single read port, checking parent and the
//   three neighbors in each entry, and the result lands in the output
//   register.
// Reset clears the entry count, the mode and the output valid; the table
//   memory itself is not cleared.
// A stalled result holds in the output register; the next beat is still
//   taken, and a query only waits at its final step if the register is full.
`default_nettype none

module coarse_fine_residual_engine
   import cfre_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MIX,
      S_PRED,
      S_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic            rdv_ff, rdv_in;
   logic            mode_ff, mode_in;
   key_type         key_ff [4];
   key_type         key_in [4];
   logic [3:0]      found_ff, found_in;
   value_type       hit_ff [4];
   value_type       hit_in [4];
   logic            odd_x_ff, odd_x_in;
   logic            odd_y_ff, odd_y_in;
   value_type       qval_ff, qval_in;
   value_type       t1_ff, t1_in;
   value_type       t2_ff, t2_in;
   logic            miss_ff, miss_in;
   value_type       pred_ff, pred_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   entry_type       entry_mem [TABLE_DEPTH];
   entry_type       rd_data_ff;

   logic            accept;
   logic            load_we;
   logic            rd_en;
   coord_type       px, py;
   value_type       n2, n3, n4;
   logic signed [VALUE_BITS:0] diff;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_we   = accept && (req_data.kind == KIND_LOAD) && (count_ff < DEPTH_CNT);
   assign rd_en     = (state_ff == S_SCAN) && (scan_ff < count_ff);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign px        = req_data.coord_x >> 1;
   assign py        = req_data.coord_y >> 1;
   assign diff      = {qval_ff[VALUE_BITS-1], qval_ff} - {pred_ff[VALUE_BITS-1], pred_ff};

   // Table memory: write on load, registered read during the scan
   always_ff @(posedge clock) begin
      if (load_we) begin
         entry_mem[count_ff[AW-1:0]] <= '{key: '{x: req_data.coord_x, y: req_data.coord_y},
                                          value: req_data.sample_value};
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[scan_ff[AW-1:0]];
      end
   end

   // Neighbor picks: absent reads as -1.0, unneeded falls back to the parent
   always_comb begin
      n2 = odd_x_ff ? (found_ff[1] ? hit_ff[1] : MINUS_ONE) : hit_ff[0];
      n3 = (odd_x_ff && odd_y_ff) ? (found_ff[2] ? hit_ff[2] : MINUS_ONE) : hit_ff[0];
      n4 = odd_y_ff ? (found_ff[3] ? hit_ff[3] : MINUS_ONE) : hit_ff[0];
   end

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rdv_in       = 1'b0;
      mode_in      = mode_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      odd_x_in     = odd_x_ff;
      odd_y_in     = odd_y_ff;
      qval_in      = qval_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      miss_in      = miss_ff;
      pred_in      = pred_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // Take a mode write
      if (csr_valid) begin
         mode_in = csr_data;
      end

      // Record the first match of each key among returning entries
      if (rdv_ff) begin
         for (int k = 0; k < 4; k++) begin
            if (!found_ff[k] && (rd_data_ff.key == key_ff[k])) begin
               found_in[k] = 1'b1;
               hit_in[k]   = rd_data_ff.value;
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  KIND_LOAD: begin
                     if (count_ff < DEPTH_CNT) begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_QUERY: begin
                     key_in[0] = '{x: px,        y: py};
                     key_in[1] = '{x: px + 1'b1, y: py};
                     key_in[2] = '{x: px + 1'b1, y: py + 1'b1};
                     key_in[3] = '{x: px,        y: py + 1'b1};
                     odd_x_in  = req_data.coord_x[0] && mode_ff;
                     odd_y_in  = req_data.coord_y[0] && mode_ff;
                     qval_in   = req_data.sample_value;
                     found_in  = '0;
                     scan_in   = '0;
                     state_in  = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue one read per cycle; the last return is folded in on exit
            if (scan_ff < count_ff) begin
               scan_in = scan_ff + 1'b1;
               rdv_in  = 1'b1;
            end else begin
               state_in = S_MIX;
            end
         end
         S_MIX: begin
            // Drop a query without a parent; else blend along y
            if (!found_ff[0]) begin
               state_in = S_IDLE;
            end else begin
               miss_in  = (odd_x_ff && !found_ff[1]) ||
                          (odd_x_ff && odd_y_ff && !found_ff[2]) ||
                          (odd_y_ff && !found_ff[3]);
               t1_in    = odd_y_ff ? half_blend(hit_ff[0], n4) : hit_ff[0];
               t2_in    = odd_y_ff ? half_blend(n2, n3) : n2;
               state_in = S_PRED;
            end
         end
         S_PRED: begin
            // Blend along x
            pred_in  = odd_x_ff ? half_blend(t1_ff, t2_ff) : t1_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Saturate and load the output register once it is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.neighbor_missing = miss_ff;
               if (diff[VALUE_BITS] != diff[VALUE_BITS-1]) begin
                  rsp_data_in.delta     = diff[VALUE_BITS] ? VALUE_MIN : VALUE_MAX;
                  rsp_data_in.saturated = 1'b1;
               end else begin
                  rsp_data_in.delta     = diff[VALUE_BITS-1:0];
                  rsp_data_in.saturated = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rdv_ff       <= rdv_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      hit_ff      <= hit_in;
      odd_x_ff    <= odd_x_in;
      odd_y_ff    <= odd_y_in;
      qval_ff     <= qval_in;
      t1_ff       <= t1_in;
      t2_ff       <= t2_in;
      miss_ff     <= miss_in;
      pred_ff     <= pred_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ src/cfre_checker.sv @@
// Port-level checks for the coarse/fine residual engine, bound to its top level.
// Depends on cfre_pkg and coarse_fine_residual_engine.
`default_nettype none

module cfre_checker
   import cfre_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled result beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped under stall");

   // A query beat occupies the block for at least the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == KIND_QUERY |=> req_stall)
      else $error("query did not start a scan");

   // Clear and load beats leave the request channel open for the next beat
   a_table_op_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.kind == KIND_CLEAR || req_data.kind == KIND_LOAD)
      |=> !req_stall)
      else $error("table operation held the request channel");

   // A clipped delta sits at one end of the range
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
      (rsp_data.delta == VALUE_MAX || rsp_data.delta == VALUE_MIN))
      else $error("saturated delta off the rail");

endmodule

bind coarse_fine_residual_engine cfre_checker u_cfre_checker (.*);

`default_nettype wire
